[rtl/core/boot_recovery_supervisor_core_assert.svh]
// ----------------------------------------------------------------------------
// Boot recovery supervisor assertion macros
// Concurrent assertion shorthands shared by the supervisor RTL.
// ----------------------------------------------------------------------------
`ifndef BOOT_RECOVERY_SUPERVISOR_CORE_ASSERT_SVH
`define BOOT_RECOVERY_SUPERVISOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/brs_pkg.sv]
// ----------------------------------------------------------------------------
// Boot recovery supervisor package
// Codes, state and result types shared by the supervisor modules.
// ----------------------------------------------------------------------------
package brs_pkg;

   // operations
   localparam logic [1:0] OP_INIT     = 2'd0;
   localparam logic [1:0] OP_BEGIN    = 2'd1;
   localparam logic [1:0] OP_COMPLETE = 2'd2;
   localparam logic [1:0] OP_FAULT    = 2'd3;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BADARG    = 3'd1;
   localparam logic [2:0] ST_BADSTATE  = 3'd2;
   localparam logic [2:0] ST_TIMEREG   = 3'd3;
   localparam logic [2:0] ST_EXHAUSTED = 3'd4;
   localparam logic [2:0] ST_STALE     = 3'd5;

   // phases
   localparam logic [3:0] PH_COLD     = 4'd0;
   localparam logic [3:0] PH_START    = 4'd1;
   localparam logic [3:0] PH_MIC      = 4'd2;
   localparam logic [3:0] PH_TESTS    = 4'd3;
   localparam logic [3:0] PH_SERVICES = 4'd4;
   localparam logic [3:0] PH_OPER     = 4'd5;
   localparam logic [3:0] PH_QUIESCE  = 4'd6;
   localparam logic [3:0] PH_SAFE     = 4'd7;
   localparam logic [3:0] PH_UNAVAIL  = 4'd8;

   // reasons
   localparam logic [3:0] RS_NONE       = 4'd0;
   localparam logic [3:0] RS_WATCHDOG   = 4'd1;
   localparam logic [3:0] RS_PERSISTED  = 4'd2;
   localparam logic [3:0] RS_EXPLICIT   = 4'd3;
   localparam logic [3:0] RS_TRANSPORT  = 4'd4;
   localparam logic [3:0] RS_MIC        = 4'd5;
   localparam logic [3:0] RS_SELFTEST   = 4'd6;
   localparam logic [3:0] RS_SERVICES   = 4'd7;
   localparam logic [3:0] RS_FAULT      = 4'd8;
   localparam logic [3:0] RS_QUIESCE    = 4'd9;

   // completion outcomes
   localparam logic [3:0] OC_TR_READY   = 4'd0;
   localparam logic [3:0] OC_TR_FAIL    = 4'd1;
   localparam logic [3:0] OC_MIC_OK     = 4'd2;
   localparam logic [3:0] OC_MIC_FAIL   = 4'd3;
   localparam logic [3:0] OC_TEST_PASS  = 4'd4;
   localparam logic [3:0] OC_TEST_FAIL  = 4'd5;
   localparam logic [3:0] OC_SVC_READY  = 4'd6;
   localparam logic [3:0] OC_SVC_FAIL   = 4'd7;
   localparam logic [3:0] OC_QUIESCED   = 4'd8;
   localparam logic [3:0] OC_QUIES_FAIL = 4'd9;
   localparam logic [3:0] OC_LAST       = OC_QUIES_FAIL;

   // action kinds
   localparam logic [2:0] ACT_TRANSPORT = 3'd0;
   localparam logic [2:0] ACT_MIC       = 3'd1;
   localparam logic [2:0] ACT_TESTS     = 3'd2;
   localparam logic [2:0] ACT_SERVICES  = 3'd3;
   localparam logic [2:0] ACT_QUIESCE   = 3'd4;

   // notice kinds
   localparam logic [1:0] NTC_SAFE    = 2'd0;
   localparam logic [1:0] NTC_UNAVAIL = 2'd1;
   localparam logic [1:0] NTC_AVAIL   = 2'd2;
   localparam logic [1:0] NTC_OPER    = 2'd3;

   // readiness flag bit positions
   localparam int unsigned FB_TRANSPORT = 0;
   localparam int unsigned FB_MIC       = 1;
   localparam int unsigned FB_TESTS     = 2;
   localparam int unsigned FB_SERVICES  = 3;
   localparam int unsigned FB_CAPTURE   = 4;

   // configuration register indexes
   localparam logic [1:0] CSR_WATCHDOG  = 2'd0;
   localparam logic [1:0] CSR_PERSISTED = 2'd1;
   localparam logic [1:0] CSR_EXPLICIT  = 2'd2;
   localparam logic [1:0] CSR_VERSION   = 2'd3;

   typedef struct packed {
      logic wdog;
      logic persisted;
      logic explicit_req;
   } evidence_type;

   typedef struct packed {
      logic        init;
      logic [3:0]  phase;
      logic [3:0]  cause;
      logic        safe_req;
      logic [4:0]  flags;
      logic [63:0] last_time;
      logic [63:0] pending_tag;
      logic [63:0] next_tag;
   } state_type;

   // cold, uninitialized, first tag 1
   localparam state_type STATE_RESET = '{
      init:        1'b0,
      phase:       PH_COLD,
      cause:       RS_NONE,
      safe_req:    1'b0,
      flags:       5'd0,
      last_time:   64'd0,
      pending_tag: 64'd0,
      next_tag:    64'd1
   };

   typedef struct packed {
      logic [2:0]  status;
      logic        act_v;
      logic [2:0]  act_k;
      logic [63:0] act_tag;
      logic        ntc_v;
      logic [1:0]  ntc_k;
      logic [3:0]  ntc_c;
      logic [63:0] stamp;
      logic [3:0]  phase_now;
      logic [3:0]  cause_now;
      logic [4:0]  flags_now;
      logic        capture;
   } result_type;

endpackage

[rtl/core/brs_eval.sv]
// ----------------------------------------------------------------------------
// Boot recovery supervisor event evaluation
// Checks one event against the state and computes next state and result.
// ----------------------------------------------------------------------------
module brs_eval (
   input  brs_pkg::state_type    state_cur,
   input  brs_pkg::evidence_type evidence,
   input  logic [1:0]            operation,
   input  logic [63:0]           event_time_ms,
   input  logic [63:0]           step_tag,
   input  logic [3:0]            outcome_code,
   output brs_pkg::state_type    state_nxt,
   output brs_pkg::result_type   result
);

   function automatic logic state_bad(input brs_pkg::state_type s);
      logic cap;
      logic tr;
      logic bad;
      cap = s.flags[brs_pkg::FB_CAPTURE];
      tr  = s.flags[brs_pkg::FB_TRANSPORT];
      bad = !s.init;
      if (cap && (s.phase != brs_pkg::PH_OPER || s.safe_req || !(&s.flags[3:0])))
         bad = 1'b1;
      if (s.phase == brs_pkg::PH_OPER && !cap)
         bad = 1'b1;
      if ((s.phase == brs_pkg::PH_SAFE || s.phase == brs_pkg::PH_QUIESCE) && (!tr || cap))
         bad = 1'b1;
      if (s.phase == brs_pkg::PH_UNAVAIL && (tr || cap))
         bad = 1'b1;
      return bad;
   endfunction

   brs_pkg::state_type  work;
   brs_pkg::result_type res;
   logic [2:0]          status;
   logic                do_issue;
   logic [2:0]          issue_kind;
   logic                safe_go;
   logic [3:0]          safe_why;

   always_comb begin
      work       = state_cur;
      res        = '0;
      status     = brs_pkg::ST_OK;
      do_issue   = 1'b0;
      issue_kind = brs_pkg::ACT_TRANSPORT;
      safe_go    = 1'b0;
      safe_why   = brs_pkg::RS_NONE;
      state_nxt  = state_cur;

      if (operation == brs_pkg::OP_INIT) begin
         state_nxt          = '0;
         state_nxt.next_tag = 64'd1;
         state_nxt.init     = 1'b1;
         priority if (evidence.wdog) begin
            state_nxt.safe_req = 1'b1;
            state_nxt.cause    = brs_pkg::RS_WATCHDOG;
         end else if (evidence.persisted) begin
            state_nxt.safe_req = 1'b1;
            state_nxt.cause    = brs_pkg::RS_PERSISTED;
         end else if (evidence.explicit_req) begin
            state_nxt.safe_req = 1'b1;
            state_nxt.cause    = brs_pkg::RS_EXPLICIT;
         end
      end else begin
         work.last_time = event_time_ms;
         priority if (state_bad(state_cur)) begin
            status = brs_pkg::ST_BADSTATE;
         end else if (event_time_ms < state_cur.last_time) begin
            status = brs_pkg::ST_TIMEREG;
         end else begin
            unique case (operation)
               brs_pkg::OP_BEGIN: begin
                  if (state_cur.phase != brs_pkg::PH_COLD) begin
                     status = brs_pkg::ST_BADSTATE;
                  end else begin
                     work.phase = brs_pkg::PH_START;
                     do_issue   = 1'b1;
                     issue_kind = brs_pkg::ACT_TRANSPORT;
                  end
               end
               brs_pkg::OP_FAULT: begin
                  if (state_cur.phase != brs_pkg::PH_OPER) begin
                     status = brs_pkg::ST_BADSTATE;
                  end else begin
                     work.flags[brs_pkg::FB_CAPTURE] = 1'b0;
                     work.safe_req = 1'b1;
                     work.cause    = brs_pkg::RS_FAULT;
                     work.phase    = brs_pkg::PH_QUIESCE;
                     do_issue      = 1'b1;
                     issue_kind    = brs_pkg::ACT_QUIESCE;
                  end
               end
               brs_pkg::OP_COMPLETE: begin
                  priority if (outcome_code > brs_pkg::OC_LAST) begin
                     status = brs_pkg::ST_BADARG;
                  end else if (step_tag == 64'd0 || step_tag != state_cur.pending_tag) begin
                     status = brs_pkg::ST_STALE;
                  end else begin
                     unique case (state_cur.phase)
                        brs_pkg::PH_START: begin
                           if (outcome_code == brs_pkg::OC_TR_FAIL) begin
                              work.phase = brs_pkg::PH_UNAVAIL;
                              work.cause = brs_pkg::RS_TRANSPORT;
                              work.flags[brs_pkg::FB_CAPTURE] = 1'b0;
                              res.ntc_v = 1'b1;
                              res.ntc_k = brs_pkg::NTC_UNAVAIL;
                              res.ntc_c = brs_pkg::RS_TRANSPORT;
                              res.stamp = event_time_ms;
                           end else if (outcome_code != brs_pkg::OC_TR_READY) begin
                              status = brs_pkg::ST_BADSTATE;
                           end else begin
                              work.flags[brs_pkg::FB_TRANSPORT] = 1'b1;
                              work.phase = brs_pkg::PH_MIC;
                              res.ntc_v  = 1'b1;
                              res.ntc_k  = brs_pkg::NTC_AVAIL;
                              res.ntc_c  = brs_pkg::RS_NONE;
                              res.stamp  = event_time_ms;
                              do_issue   = 1'b1;
                              issue_kind = brs_pkg::ACT_MIC;
                           end
                        end
                        brs_pkg::PH_MIC: begin
                           if (outcome_code == brs_pkg::OC_MIC_FAIL) begin
                              work.flags[brs_pkg::FB_MIC] = 1'b0;
                              safe_go  = 1'b1;
                              safe_why = brs_pkg::RS_MIC;
                           end else if (outcome_code != brs_pkg::OC_MIC_OK) begin
                              status = brs_pkg::ST_BADSTATE;
                           end else begin
                              work.flags[brs_pkg::FB_MIC] = 1'b1;
                              if (state_cur.safe_req) begin
                                 safe_go  = 1'b1;
                                 safe_why = state_cur.cause;
                              end else begin
                                 work.phase = brs_pkg::PH_TESTS;
                                 do_issue   = 1'b1;
                                 issue_kind = brs_pkg::ACT_TESTS;
                              end
                           end
                        end
                        brs_pkg::PH_TESTS: begin
                           if (outcome_code == brs_pkg::OC_TEST_FAIL) begin
                              safe_go  = 1'b1;
                              safe_why = brs_pkg::RS_SELFTEST;
                           end else if (outcome_code != brs_pkg::OC_TEST_PASS) begin
                              status = brs_pkg::ST_BADSTATE;
                           end else begin
                              work.flags[brs_pkg::FB_TESTS] = 1'b1;
                              work.phase = brs_pkg::PH_SERVICES;
                              do_issue   = 1'b1;
                              issue_kind = brs_pkg::ACT_SERVICES;
                           end
                        end
                        brs_pkg::PH_SERVICES: begin
                           if (outcome_code == brs_pkg::OC_SVC_FAIL) begin
                              safe_go  = 1'b1;
                              safe_why = brs_pkg::RS_SERVICES;
                           end else if (outcome_code != brs_pkg::OC_SVC_READY) begin
                              status = brs_pkg::ST_BADSTATE;
                           end else begin
                              work.flags[brs_pkg::FB_SERVICES] = 1'b1;
                              work.flags[brs_pkg::FB_CAPTURE]  = 1'b1;
                              work.phase = brs_pkg::PH_OPER;
                              work.cause = brs_pkg::RS_NONE;
                              res.ntc_v  = 1'b1;
                              res.ntc_k  = brs_pkg::NTC_OPER;
                              res.ntc_c  = brs_pkg::RS_NONE;
                              res.stamp  = event_time_ms;
                           end
                        end
                        brs_pkg::PH_QUIESCE: begin
                           if (outcome_code == brs_pkg::OC_QUIES_FAIL) begin
                              work.flags[brs_pkg::FB_MIC] = 1'b0;
                              safe_go  = 1'b1;
                              safe_why = brs_pkg::RS_QUIESCE;
                           end else if (outcome_code != brs_pkg::OC_QUIESCED) begin
                              status = brs_pkg::ST_BADSTATE;
                           end else begin
                              work.flags[brs_pkg::FB_MIC] = 1'b1;
                              safe_go  = 1'b1;
                              safe_why = brs_pkg::RS_FAULT;
                           end
                        end
                        default: begin
                           status = brs_pkg::ST_BADSTATE;
                        end
                     endcase
                  end
               end
               default: begin
                  status = brs_pkg::ST_BADSTATE;
               end
            endcase

            if (safe_go) begin
               work.phase    = brs_pkg::PH_SAFE;
               work.cause    = safe_why;
               work.safe_req = 1'b1;
               work.flags[brs_pkg::FB_CAPTURE]  = 1'b0;
               work.flags[brs_pkg::FB_SERVICES] = 1'b0;
               res.ntc_v = 1'b1;
               res.ntc_k = brs_pkg::NTC_SAFE;
               res.ntc_c = safe_why;
               res.stamp = event_time_ms;
            end

            // tag allocation; a wrapped counter means the tag space is used up
            if (status == brs_pkg::ST_OK && do_issue) begin
               if (work.next_tag == 64'd0) begin
                  status = brs_pkg::ST_EXHAUSTED;
               end else begin
                  work.pending_tag = work.next_tag;
                  work.next_tag    = work.next_tag + 64'd1;
                  res.act_v   = 1'b1;
                  res.act_k   = issue_kind;
                  res.act_tag = work.next_tag - 64'd1;
                  res.stamp   = event_time_ms;
               end
            end

            if (status == brs_pkg::ST_OK && state_bad(work))
               status = brs_pkg::ST_BADSTATE;
         end

         if (status == brs_pkg::ST_OK)
            state_nxt = work;
         else
            res = '0;
      end

      res.status    = status;
      res.phase_now = state_nxt.phase;
      res.cause_now = state_nxt.cause;
      res.flags_now = state_nxt.flags;
      res.capture   = state_nxt.init && state_nxt.flags[brs_pkg::FB_CAPTURE];
      result        = res;
   end

endmodule

[rtl/core/boot_recovery_supervisor_core.sv]
// ----------------------------------------------------------------------------
// Boot recovery supervisor core
// Sequences boot, self checks and recovery from a stream of events.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event per transaction (initialize, begin, step
//   completion, runtime fault). rsp_* returns exactly one result per event:
//   status, optional action with its step tag, optional notice, and the
//   phase, reason and flags after the event.
//   csr_* writes the boot evidence bits (index 0..2); csr_ready is always
//   high. Index 3 is the status format version index, which no result carries,
//   so its writes are accepted and dropped.
//   An accepted event is captured in the input register and evaluated there
//   against the state; its result then loads into the result register,
//   which drives rsp_valid. Throughput is one event per cycle while the
//   result is not stalled; the state loop closes through the evaluation
//   logic (compares and a 64-bit tag increment).
//   Reset clears the state to cold, uninitialized, next tag 1, and empties
//   both registers. While rsp_stall is high the result holds and, once the
//   input register is also full, req_stall rises.
// ----------------------------------------------------------------------------
`include "boot_recovery_supervisor_core_assert.svh"

module boot_recovery_supervisor_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_event_time_ms,
   input  logic [63:0] req_step_tag,
   input  logic [3:0]  req_outcome_code,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status_code,
   output logic        rsp_action_valid,
   output logic [2:0]  rsp_action_kind,
   output logic [63:0] rsp_action_tag,
   output logic        rsp_notice_valid,
   output logic [1:0]  rsp_notice_kind,
   output logic [3:0]  rsp_notice_cause,
   output logic [63:0] rsp_stamp_ms,
   output logic [3:0]  rsp_phase_now,
   output logic [3:0]  rsp_cause_now,
   output logic [5:0]  rsp_status_flags,
   output logic        rsp_capture_allowed,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            op_ff;
   logic [63:0]           time_ff;
   logic [63:0]           tag_ff;
   logic [3:0]            oc_ff;
   logic                  out_valid_ff, out_valid_in;
   brs_pkg::result_type   res_ff, res_in;
   brs_pkg::state_type    state_ff, state_in;
   brs_pkg::evidence_type evid_ff, evid_in;

   brs_pkg::state_type    eval_state;
   brs_pkg::result_type   eval_result;

   logic                  advance;
   logic                  fire;
   logic                  req_take;
   logic                  rsp_take;
   logic                  csr_take;

   assign advance  = !out_valid_ff || !rsp_stall;
   assign fire     = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign rsp_take = out_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   brs_eval u_eval (
      .state_cur     (state_ff),
      .evidence      (evid_ff),
      .operation     (op_ff),
      .event_time_ms (time_ff),
      .step_tag      (tag_ff),
      .outcome_code  (oc_ff),
      .state_nxt     (eval_state),
      .result        (eval_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (fire)
         in_valid_in = 1'b0;
      if (req_take)
         in_valid_in = 1'b1;

      out_valid_in = out_valid_ff;
      if (rsp_take)
         out_valid_in = 1'b0;
      if (fire)
         out_valid_in = 1'b1;

      state_in = fire ? eval_state : state_ff;
      res_in   = fire ? eval_result : res_ff;

      evid_in = evid_ff;
      if (csr_take) begin
         unique case (csr_index)
            brs_pkg::CSR_WATCHDOG:  evid_in.wdog         = csr_wdata[0];
            brs_pkg::CSR_PERSISTED: evid_in.persisted    = csr_wdata[0];
            brs_pkg::CSR_EXPLICIT:  evid_in.explicit_req = csr_wdata[0];
            brs_pkg::CSR_VERSION:   evid_in = evid_ff;
            default:                evid_in = evid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         evid_ff      <= '0;
         state_ff     <= brs_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         evid_ff      <= evid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff   <= req_operation;
         time_ff <= req_event_time_ms;
         tag_ff  <= req_step_tag;
         oc_ff   <= req_outcome_code;
      end
      res_ff <= res_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status_code     = res_ff.status;
   assign rsp_action_valid    = res_ff.act_v;
   assign rsp_action_kind     = res_ff.act_k;
   assign rsp_action_tag      = res_ff.act_tag;
   assign rsp_notice_valid    = res_ff.ntc_v;
   assign rsp_notice_kind     = res_ff.ntc_k;
   assign rsp_notice_cause    = res_ff.ntc_c;
   assign rsp_stamp_ms        = res_ff.stamp;
   assign rsp_phase_now       = res_ff.phase_now;
   assign rsp_cause_now       = res_ff.cause_now;
   assign rsp_status_flags    = {1'b1, res_ff.flags_now};
   assign rsp_capture_allowed = res_ff.capture;

   `BRS_ASSERT_IMPLY(a_err_no_output, clock, reset,
      out_valid_ff && res_ff.status != brs_pkg::ST_OK,
      !res_ff.act_v && !res_ff.ntc_v, "error result carries an action or notice")
   `BRS_ASSERT_IMPLY(a_capture_oper, clock, reset,
      out_valid_ff && res_ff.capture,
      res_ff.phase_now == brs_pkg::PH_OPER, "capture allowed outside operational")
   `BRS_ASSERT_NEXT(a_action_tag_pending, clock, reset,
      fire && eval_result.act_v,
      state_ff.pending_tag == res_ff.act_tag &&
      state_ff.next_tag == res_ff.act_tag + 64'd1, "issued tag not recorded as pending")
   `BRS_ASSERT_IMPLY(a_empty_no_stall, clock, reset,
      !in_valid_ff, !req_stall, "input stalled while input register empty")

endmodule
